// ===== rtl/arut_pkg.sv =====
// Package for the address range union table: sizes, control word layout and microcode.
`default_nettype none

package arut_pkg;

	localparam int TABLE_DEPTH = 64;
	localparam int ADDR_W      = 16;
	localparam int IDX_W       = $clog2(TABLE_DEPTH);
	localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
	localparam int ENTRY_W     = 2 * ADDR_W;
	localparam int STEP_W      = 5;

	localparam logic [1:0] ST_OK   = 2'd0;
	localparam logic [1:0] ST_FULL = 2'd1;
	localparam logic [1:0] ST_BAD  = 2'd2;

	// step addresses
	localparam logic [STEP_W-1:0] S_IDLE   = 5'd0;
	localparam logic [STEP_W-1:0] S_DISP   = 5'd1;
	localparam logic [STEP_W-1:0] S_CHK    = 5'd2;
	localparam logic [STEP_W-1:0] S_A_RD   = 5'd3;
	localparam logic [STEP_W-1:0] S_A_BEF  = 5'd4;
	localparam logic [STEP_W-1:0] S_A_AFT  = 5'd5;
	localparam logic [STEP_W-1:0] S_B_RD   = 5'd6;
	localparam logic [STEP_W-1:0] S_B_AFT  = 5'd7;
	localparam logic [STEP_W-1:0] S_B_EXT  = 5'd8;
	localparam logic [STEP_W-1:0] S_M_WR   = 5'd9;
	localparam logic [STEP_W-1:0] S_M_RD   = 5'd10;
	localparam logic [STEP_W-1:0] S_M_CP   = 5'd11;
	localparam logic [STEP_W-1:0] S_M_END  = 5'd12;
	localparam logic [STEP_W-1:0] S_N_CHK  = 5'd13;
	localparam logic [STEP_W-1:0] S_N_RD   = 5'd14;
	localparam logic [STEP_W-1:0] S_N_CP   = 5'd15;
	localparam logic [STEP_W-1:0] S_N_WR   = 5'd16;
	localparam logic [STEP_W-1:0] S_RD_ISS = 5'd17;
	localparam logic [STEP_W-1:0] S_RD_CAP = 5'd18;
	localparam logic [STEP_W-1:0] S_BAD    = 5'd19;
	localparam logic [STEP_W-1:0] S_FULL   = 5'd20;
	localparam logic [STEP_W-1:0] S_FIN    = 5'd21;
	localparam logic [STEP_W-1:0] S_FIN_W  = 5'd22;

	typedef enum logic [3:0] {
		C_NEXT, C_ALWAYS, C_NO_IN, C_READ, C_BAD, C_K_END, C_BEFORE,
		C_AFTER, C_FULL, C_K_LO, C_IDX_BAD, C_OUT_FREE
	} cond_t;

	typedef enum logic [1:0] {RD_NONE, RD_K, RD_KM1, RD_IDX} rd_sel_t;
	typedef enum logic [2:0] {WR_NONE, WR_LO_MERGED, WR_LO_NEW, WR_LO_COPY, WR_KP1_COPY} wr_sel_t;
	typedef enum logic [2:0] {K_HOLD, K_ZERO, K_INC, K_DEC, K_LD_HI, K_LD_CNT} k_op_t;
	typedef enum logic [1:0] {LO_HOLD, LO_LD_K, LO_INC} lo_op_t;
	typedef enum logic [1:0] {MS_HOLD, MS_INIT, MS_EXT} ms_op_t;
	typedef enum logic [1:0] {CNT_HOLD, CNT_LD_LO, CNT_INC} cnt_op_t;
	typedef enum logic [1:0] {SO_HOLD, SO_OK, SO_FULL, SO_BAD} st_op_t;

	typedef struct packed {
		cond_t             cond;
		logic [STEP_W-1:0] target;
		rd_sel_t           rd;
		wr_sel_t           wr;
		k_op_t             k_op;
		lo_op_t            lo_op;
		logic              hi_ld;
		ms_op_t            ms_op;
		cnt_op_t           cnt_op;
		st_op_t            st_op;
		logic              rd_clr;
		logic              rd_ld;
		logic              out_ld;
	} ucode_t;

	localparam ucode_t UC_NOP = '{
		cond: C_NEXT, target: S_IDLE, rd: RD_NONE, wr: WR_NONE, k_op: K_HOLD,
		lo_op: LO_HOLD, hi_ld: 1'b0, ms_op: MS_HOLD, cnt_op: CNT_HOLD,
		st_op: SO_HOLD, rd_clr: 1'b0, rd_ld: 1'b0, out_ld: 1'b0
	};

	// Jumps go to target when the condition holds, else to the next step.
	function automatic ucode_t ucode_rom(input logic [STEP_W-1:0] step);
		ucode_t w;
		w = UC_NOP;
		case (step)
			S_IDLE: begin
				w.cond = C_NO_IN; w.target = S_IDLE;
			end
			S_DISP: begin
				w.cond = C_READ; w.target = S_RD_ISS;
				w.k_op = K_ZERO; w.rd_clr = 1'b1;
			end
			S_CHK: begin
				w.cond = C_BAD; w.target = S_BAD;
			end
			// find first entry that reaches the new start
			S_A_RD: begin
				w.cond = C_K_END; w.target = S_N_CHK;
				w.lo_op = LO_LD_K; w.rd = RD_K; w.k_op = K_INC;
			end
			S_A_BEF: begin
				w.cond = C_BEFORE; w.target = S_A_RD;
			end
			S_A_AFT: begin
				w.cond = C_AFTER; w.target = S_N_CHK; w.ms_op = MS_INIT;
			end
			// extend over following entries that start by end + 1
			S_B_RD: begin
				w.cond = C_K_END; w.target = S_M_WR;
				w.hi_ld = 1'b1; w.rd = RD_K; w.k_op = K_INC;
			end
			S_B_AFT: begin
				w.cond = C_AFTER; w.target = S_M_WR;
			end
			S_B_EXT: begin
				w.cond = C_ALWAYS; w.target = S_B_RD; w.ms_op = MS_EXT;
			end
			// write the merged entry, then pull the tail up
			S_M_WR: begin
				w.wr = WR_LO_MERGED; w.k_op = K_LD_HI; w.lo_op = LO_INC;
			end
			S_M_RD: begin
				w.cond = C_K_END; w.target = S_M_END; w.rd = RD_K; w.k_op = K_INC;
			end
			S_M_CP: begin
				w.cond = C_ALWAYS; w.target = S_M_RD; w.wr = WR_LO_COPY; w.lo_op = LO_INC;
			end
			S_M_END: begin
				w.cond = C_ALWAYS; w.target = S_FIN; w.cnt_op = CNT_LD_LO; w.st_op = SO_OK;
			end
			// no overlap: open a gap at lo by shifting the tail down
			S_N_CHK: begin
				w.cond = C_FULL; w.target = S_FULL; w.k_op = K_LD_CNT;
			end
			S_N_RD: begin
				w.cond = C_K_LO; w.target = S_N_WR; w.rd = RD_KM1; w.k_op = K_DEC;
			end
			S_N_CP: begin
				w.cond = C_ALWAYS; w.target = S_N_RD; w.wr = WR_KP1_COPY;
			end
			S_N_WR: begin
				w.cond = C_ALWAYS; w.target = S_FIN; w.wr = WR_LO_NEW;
				w.cnt_op = CNT_INC; w.st_op = SO_OK;
			end
			S_RD_ISS: begin
				w.cond = C_IDX_BAD; w.target = S_BAD; w.rd = RD_IDX;
			end
			S_RD_CAP: begin
				w.cond = C_ALWAYS; w.target = S_FIN; w.rd_ld = 1'b1; w.st_op = SO_OK;
			end
			S_BAD: begin
				w.cond = C_ALWAYS; w.target = S_FIN; w.st_op = SO_BAD;
			end
			S_FULL: begin
				w.cond = C_ALWAYS; w.target = S_FIN; w.st_op = SO_FULL;
			end
			S_FIN: begin
				w.cond = C_OUT_FREE; w.target = S_IDLE; w.out_ld = 1'b1;
			end
			S_FIN_W: begin
				w.cond = C_ALWAYS; w.target = S_FIN;
			end
			default: begin
				w.cond = C_ALWAYS; w.target = S_IDLE;
			end
		endcase
		return w;
	endfunction

endpackage

`default_nettype wire

// ===== rtl/arut_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module arut_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

// ===== rtl/address_range_union_table.sv =====
// Sorted, coalesced table of inclusive address ranges run by a microcoded sequencer.
// Usage:
//  Requests arrive on the s_axis channel. tuser selects insert (0) or read (1);
//  tdata carries start, end and entry index. One response per request leaves on
//  m_axis with status, entry count after the request and the read bounds.
//  Insert scans from entry 0 past each entry below the new range and over each
//  entry it merges (the single RAM read port has registered read data), then
//  moves the tail one entry at a time. A read or a bad range needs no scan; an
//  insert that needs a new entry is dropped with status full on a full table.
//  One request is in flight at a time; s_axis_tready is high only while the
//  sequencer waits at its idle step. The response sits in an output register:
//  the next request is accepted while it waits. If the receiver stalls, a
//  finished second request holds in the final steps until the register frees.
//  Reset clears the entry count, the output valid flag and the sequencer; table
//  contents are not cleared and data of entries at or above the count is never used.
`default_nettype none

module address_range_union_table
	import arut_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	input  wire logic [39:0] s_axis_tdata,  // start_addr[15:0], end_addr[31:16], entry_index[37:32]
	input  wire logic [0:0]  s_axis_tuser,  // req_type
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	output logic [47:0]      m_axis_tdata   // status[1:0], entry_count[8:2], range_start[24:9],
	                                        // range_end[40:25]
);

	logic [STEP_W-1:0] step_q;
	ucode_t            uc;

	logic              req_q;
	logic [ADDR_W-1:0] s_q, e_q, ms_q, me_q, rs_q, re_q;
	logic [IDX_W-1:0]  idx_q;
	logic [CNT_W-1:0]  cnt_q, k_q, lo_q, hi_q;
	logic [1:0]        st_q;

	logic              out_valid_q;
	logic [1:0]        out_st_q;
	logic [CNT_W-1:0]  out_cnt_q;
	logic [ADDR_W-1:0] out_rs_q, out_re_q;

	logic              ram_we, ram_re;
	logic [IDX_W-1:0]  ram_waddr, ram_raddr;
	logic [ENTRY_W-1:0] ram_wdata, ram_rdata;
	logic [ADDR_W-1:0] rd_start, rd_end;
	logic [ADDR_W:0]   rd_end_p1, e_p1;
	logic [CNT_W-1:0]  k_m1, k_p1;

	logic in_xfer, out_free, cond_hit;

	assign uc       = ucode_rom(step_q);
	assign in_xfer  = s_axis_tvalid && s_axis_tready;
	assign out_free = !out_valid_q || m_axis_tready;

	assign rd_start  = ram_rdata[ENTRY_W-1:ADDR_W];
	assign rd_end    = ram_rdata[ADDR_W-1:0];
	assign rd_end_p1 = {1'b0, rd_end} + {{ADDR_W{1'b0}}, 1'b1};
	assign e_p1      = {1'b0, e_q} + {{ADDR_W{1'b0}}, 1'b1};
	assign k_m1      = k_q - {{(CNT_W-1){1'b0}}, 1'b1};
	assign k_p1      = k_q + {{(CNT_W-1){1'b0}}, 1'b1};

	always_comb begin
		case (uc.cond)
			C_NEXT:     cond_hit = 1'b0;
			C_ALWAYS:   cond_hit = 1'b1;
			C_NO_IN:    cond_hit = !s_axis_tvalid;
			C_READ:     cond_hit = req_q;
			C_BAD:      cond_hit = s_q > e_q;
			C_K_END:    cond_hit = k_q >= cnt_q;
			C_BEFORE:   cond_hit = rd_end_p1 < {1'b0, s_q};
			C_AFTER:    cond_hit = {1'b0, rd_start} > e_p1;
			C_FULL:     cond_hit = cnt_q >= CNT_W'(TABLE_DEPTH);
			C_K_LO:     cond_hit = k_q == lo_q;
			C_IDX_BAD:  cond_hit = {1'b0, idx_q} >= cnt_q;
			C_OUT_FREE: cond_hit = out_free;
			default:    cond_hit = 1'b0;
		endcase
	end

	// memory port selection
	always_comb begin
		ram_re    = 1'b1;
		ram_raddr = k_q[IDX_W-1:0];
		case (uc.rd)
			RD_NONE: ram_re = 1'b0;
			RD_K:    ram_raddr = k_q[IDX_W-1:0];
			RD_KM1:  ram_raddr = k_m1[IDX_W-1:0];
			RD_IDX:  ram_raddr = idx_q;
			default: ram_re = 1'b0;
		endcase
	end

	always_comb begin
		ram_we    = 1'b1;
		ram_waddr = lo_q[IDX_W-1:0];
		ram_wdata = ram_rdata;
		case (uc.wr)
			WR_NONE:      ram_we = 1'b0;
			WR_LO_MERGED: ram_wdata = {ms_q, me_q};
			WR_LO_NEW:    ram_wdata = {s_q, e_q};
			WR_LO_COPY:   ram_wdata = ram_rdata;
			WR_KP1_COPY:  ram_waddr = k_p1[IDX_W-1:0];
			default:      ram_we = 1'b0;
		endcase
	end

	arut_ram #(
		.WIDTH(ENTRY_W),
		.DEPTH(TABLE_DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// sequencer and control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q      <= S_IDLE;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			step_q <= cond_hit ? uc.target : step_q + {{(STEP_W-1){1'b0}}, 1'b1};
			case (uc.cnt_op)
				CNT_HOLD:  cnt_q <= cnt_q;
				CNT_LD_LO: cnt_q <= lo_q;
				CNT_INC:   cnt_q <= cnt_q + {{(CNT_W-1){1'b0}}, 1'b1};
				default:   cnt_q <= cnt_q;
			endcase
			if (uc.out_ld && out_free) begin
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (in_xfer) begin
			req_q <= s_axis_tuser[0];
			s_q   <= s_axis_tdata[ADDR_W-1:0];
			e_q   <= s_axis_tdata[16 +: ADDR_W];
			idx_q <= s_axis_tdata[32 +: IDX_W];
		end

		case (uc.k_op)
			K_HOLD:   k_q <= k_q;
			K_ZERO:   k_q <= '0;
			K_INC:    k_q <= k_p1;
			K_DEC:    k_q <= k_m1;
			K_LD_HI:  k_q <= hi_q;
			K_LD_CNT: k_q <= cnt_q;
			default:  k_q <= k_q;
		endcase

		case (uc.lo_op)
			LO_HOLD: lo_q <= lo_q;
			LO_LD_K: lo_q <= k_q;
			LO_INC:  lo_q <= lo_q + {{(CNT_W-1){1'b0}}, 1'b1};
			default: lo_q <= lo_q;
		endcase

		if (uc.hi_ld) begin
			hi_q <= k_q;
		end

		case (uc.ms_op)
			MS_HOLD: ;
			MS_INIT: begin
				ms_q <= (rd_start < s_q) ? rd_start : s_q;
				me_q <= (rd_end > e_q) ? rd_end : e_q;
			end
			MS_EXT:  me_q <= (rd_end > me_q) ? rd_end : me_q;
			default: ;
		endcase

		case (uc.st_op)
			SO_HOLD: st_q <= st_q;
			SO_OK:   st_q <= ST_OK;
			SO_FULL: st_q <= ST_FULL;
			SO_BAD:  st_q <= ST_BAD;
			default: st_q <= st_q;
		endcase

		if (uc.rd_clr) begin
			rs_q <= '0;
			re_q <= '0;
		end else if (uc.rd_ld) begin
			rs_q <= rd_start;
			re_q <= rd_end;
		end

		if (uc.out_ld && out_free) begin
			out_st_q  <= st_q;
			out_cnt_q <= cnt_q;
			out_rs_q  <= rs_q;
			out_re_q  <= re_q;
		end
	end

	assign s_axis_tready = step_q == S_IDLE;
	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {7'd0, out_re_q, out_rs_q, out_cnt_q, out_st_q};

endmodule

`default_nettype wire

// ===== dv/tb_address_range_union_table.sv =====
// Self-checking testbench for the address range union table: insert, merge, full and read paths.
`timescale 1ns / 1ps

module tb_address_range_union_table;
	import arut_pkg::*;

	localparam logic REQ_INSERT = 1'b0;
	localparam logic REQ_READ   = 1'b1;
	localparam int   FULL_BASE  = 1000;
	localparam int   SLOT_PITCH = 200;
	localparam int   WIN_BASE   = 14000;

	typedef struct packed {
		logic [ADDR_W-1:0] hi_addr;
		logic [ADDR_W-1:0] lo_addr;
		logic [CNT_W-1:0]  count;
		logic [1:0]        status;
	} range_result_t;

	typedef enum logic [1:0] {RX_OPEN, RX_HALF, RX_SPARSE, RX_MOSTLY} rx_mode_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [39:0] s_axis_tdata = '0;  // start_addr, end_addr, entry_index
	logic [0:0]  s_axis_tuser = '0;  // req_type
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [47:0] m_axis_tdata;       // status, entry_count, range_start, range_end

	// shadow copy of the table
	logic [ADDR_W-1:0] shadow_start [TABLE_DEPTH];
	logic [ADDR_W-1:0] shadow_end   [TABLE_DEPTH];
	int                shadow_count = 0;

	range_result_t pending_results [$];
	int fail_count = 0;
	int burst_left = 0;
	int n_inserts = 0, n_merges = 0, n_full = 0, n_reads = 0, n_bad = 0, n_checked = 0;

	rx_mode_t rx_mode = RX_OPEN;
	int       rx_left = 0;

	address_range_union_table u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// Applies one request to the shadow table and returns the response it must produce.
	function automatic range_result_t apply_request(logic req, logic [ADDR_W-1:0] s_in,
			logic [ADDR_W-1:0] e_in, logic [IDX_W-1:0] idx);
		range_result_t r;
		int lo, hi, k, merged, s, e;
		r = '0;
		r.status = ST_OK;
		if (req == REQ_READ) begin
			n_reads++;
			if (idx < shadow_count) begin
				r.lo_addr = shadow_start[idx];
				r.hi_addr = shadow_end[idx];
			end else begin
				r.status = ST_BAD;
				n_bad++;
			end
		end else if (s_in > e_in) begin
			r.status = ST_BAD;
			n_bad++;
		end else begin
			n_inserts++;
			s = int'(s_in);
			e = int'(e_in);
			// touch test is done in 32 bits so the top address never wraps
			lo = 0;
			while (lo < shadow_count && int'(shadow_end[lo]) + 1 < s)
				lo++;
			hi = lo;
			while (hi < shadow_count && int'(shadow_start[hi]) <= e + 1)
				hi++;
			merged = hi - lo;
			if (merged == 0) begin
				if (shadow_count >= TABLE_DEPTH) begin
					r.status = ST_FULL;
					n_full++;
				end else begin
					for (k = shadow_count; k > lo; k--) begin
						shadow_start[k] = shadow_start[k-1];
						shadow_end[k]   = shadow_end[k-1];
					end
					shadow_start[lo] = s_in;
					shadow_end[lo]   = e_in;
					shadow_count++;
				end
			end else begin
				n_merges++;
				if (int'(shadow_start[lo]) < s)
					s = int'(shadow_start[lo]);
				if (int'(shadow_end[hi-1]) > e)
					e = int'(shadow_end[hi-1]);
				shadow_start[lo] = ADDR_W'(s);
				shadow_end[lo]   = ADDR_W'(e);
				for (k = hi; k < shadow_count; k++) begin
					shadow_start[k-merged+1] = shadow_start[k];
					shadow_end[k-merged+1]   = shadow_end[k];
				end
				shadow_count -= merged - 1;
			end
		end
		r.count = CNT_W'(shadow_count);
		return r;
	endfunction

	// record the expected response of every accepted request
	always @(posedge clk) begin
		if (arst_n && s_axis_tvalid && s_axis_tready)
			pending_results.push_back(apply_request(s_axis_tuser[0], s_axis_tdata[15:0],
				s_axis_tdata[31:16], s_axis_tdata[37:32]));
	end

	always @(posedge clk) begin
		range_result_t want, got;
		if (m_axis_tvalid === 1'b1 && m_axis_tready) begin
			got = range_result_t'(m_axis_tdata[40:0]);
			n_checked++;
			if (pending_results.size() == 0) begin
				$error("response with no request outstanding: %h", m_axis_tdata);
				fail_count++;
			end else begin
				want = pending_results.pop_front();
				if (got.status !== want.status) begin
					$error("status: expected %0d, actual %0d", want.status, got.status);
					fail_count++;
				end
				if (got.count !== want.count) begin
					$error("entry_count: expected %0d, actual %0d", want.count, got.count);
					fail_count++;
				end
				if (got.lo_addr !== want.lo_addr) begin
					$error("range_start: expected %0d, actual %0d", want.lo_addr, got.lo_addr);
					fail_count++;
				end
				if (got.hi_addr !== want.hi_addr) begin
					$error("range_end: expected %0d, actual %0d", want.hi_addr, got.hi_addr);
					fail_count++;
				end
			end
		end
	end

	// receiver backpressure: switches between stall patterns at random intervals
	always @(posedge clk) begin
		if (rx_left == 0) begin
			rx_mode = rx_mode_t'($urandom_range(0, 3));
			rx_left = $urandom_range(50, 400);
		end else begin
			rx_left--;
		end
		case (rx_mode)
			RX_OPEN:   m_axis_tready <= 1'b1;
			RX_HALF:   m_axis_tready <= ($urandom_range(0, 1) == 0);
			RX_SPARSE: m_axis_tready <= ($urandom_range(0, 7) == 0);
			default:   m_axis_tready <= ($urandom_range(0, 9) != 0);
		endcase
	end

	// Sends one request; valid stays up across back-to-back transfers of a burst.
	task automatic send_request(input logic req, input logic [ADDR_W-1:0] s,
			input logic [ADDR_W-1:0] e, input logic [IDX_W-1:0] idx);
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
			if (gap > 0) begin
				s_axis_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(1, 16);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser  <= req;
		s_axis_tdata  <= {2'b00, idx, e, s};
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		burst_left--;
	endtask

	task automatic drain_results();
		s_axis_tvalid <= 1'b0;
		burst_left = 0;
		@(posedge clk);
		while (pending_results.size() != 0)
			@(posedge clk);
	endtask

	task automatic test_directed_cases();
		send_request(REQ_READ,   16'd0,     16'd0,     6'd0);   // read of empty table
		send_request(REQ_INSERT, 16'd1,     16'd0,     6'd0);   // start above end
		send_request(REQ_INSERT, 16'hFFFF,  16'd0,     6'h3F);
		send_request(REQ_INSERT, 16'd0,     16'd0,     6'd0);
		send_request(REQ_INSERT, 16'hFFFF,  16'hFFFF,  6'd0);   // top address must not wrap to 0
		send_request(REQ_INSERT, 16'd0,     16'd0,     6'd0);   // already covered
		send_request(REQ_INSERT, 16'd2,     16'd3,     6'd0);
		send_request(REQ_INSERT, 16'd1,     16'd1,     6'd0);   // touches both neighbors
		send_request(REQ_READ,   16'hFFFF,  16'hFFFF,  6'd0);
		send_request(REQ_READ,   16'd0,     16'd0,     6'd1);
		send_request(REQ_READ,   16'd0,     16'd0,     6'd2);   // index at count
		send_request(REQ_READ,   16'd0,     16'd0,     6'h3F);
		send_request(REQ_INSERT, 16'hFFFE,  16'hFFFE,  6'd0);   // touches top entry
		send_request(REQ_INSERT, 16'd100,   16'd110,   6'd0);
		send_request(REQ_INSERT, 16'd120,   16'd130,   6'd0);
		send_request(REQ_INSERT, 16'd111,   16'd119,   6'd0);
		send_request(REQ_INSERT, 16'd50,    16'd60,    6'd0);
		send_request(REQ_INSERT, 16'd40,    16'd200,   6'd0);   // swallows two entries
		send_request(REQ_INSERT, 16'd140,   16'd150,   6'd0);   // inside: larger end is kept
		send_request(REQ_INSERT, 16'd30,    16'd45,    6'd0);   // extends start only
		send_request(REQ_READ,   16'd0,     16'd0,     6'd1);
		send_request(REQ_READ,   16'd0,     16'd0,     6'd2);
	endtask

	task automatic test_table_full();
		int slot_of [TABLE_DEPTH];
		int i, j, t, need, s;
		drain_results();
		need = TABLE_DEPTH - shadow_count;
		for (i = 0; i < TABLE_DEPTH; i++)
			slot_of[i] = i;
		for (i = TABLE_DEPTH - 1; i > 0; i--) begin
			j = $urandom_range(0, i);
			t = slot_of[i];
			slot_of[i] = slot_of[j];
			slot_of[j] = t;
		end
		// fill in random order so inserts land at many positions and exercise the tail shift
		for (i = 0; i < need; i++) begin
			s = FULL_BASE + slot_of[i] * SLOT_PITCH;
			send_request(REQ_INSERT, ADDR_W'(s), ADDR_W'(s + $urandom_range(0, 100)),
				IDX_W'($urandom));
		end
		send_request(REQ_INSERT, 16'd500, 16'd600, IDX_W'($urandom));   // needs a new entry: dropped
		s = FULL_BASE + slot_of[0] * SLOT_PITCH;
		send_request(REQ_INSERT, ADDR_W'(s - 5), ADDR_W'(s), IDX_W'($urandom));  // merges, so accepted
		send_request(REQ_READ, ADDR_W'($urandom), ADDR_W'($urandom), 6'h3F);
		send_request(REQ_READ, ADDR_W'($urandom), ADDR_W'($urandom), 6'd0);
		send_request(REQ_READ, ADDR_W'($urandom), ADDR_W'($urandom), IDX_W'($urandom));
		send_request(REQ_INSERT, ADDR_W'(FULL_BASE - 10),
			ADDR_W'(FULL_BASE + TABLE_DEPTH * SLOT_PITCH), IDX_W'($urandom));
		send_request(REQ_READ, ADDR_W'($urandom), ADDR_W'($urandom), 6'd3);
		send_request(REQ_READ, ADDR_W'($urandom), ADDR_W'($urandom), 6'd4);
	endtask

	// Each window of fresh address space gets a run of requests, then one insert folds it.
	task automatic test_random_windows(input int item_goal);
		int base, span, n, i, s, e, len, pick, sent;
		logic [IDX_W-1:0] idx;
		base = WIN_BASE;
		sent = 0;
		while (sent < item_goal && base + 1100 < 65535) begin
			span = $urandom_range(64, 1024);
			n = $urandom_range(20, 60);
			for (i = 0; i < n; i++) begin
				pick = $urandom_range(0, 99);
				if (pick < 65) begin
					s = base + $urandom_range(0, span - 1);
					len = ($urandom_range(0, 4) == 0) ? $urandom_range(0, span / 2)
						: $urandom_range(0, 8);
					if (s + len > base + span - 1)
						len = base + span - 1 - s;
					send_request(REQ_INSERT, ADDR_W'(s), ADDR_W'(s + len), IDX_W'($urandom));
				end else if (pick < 88) begin
					idx = (shadow_count > 63) ? IDX_W'($urandom_range(0, 63))
						: IDX_W'($urandom_range(0, shadow_count));
					send_request(REQ_READ, ADDR_W'($urandom), ADDR_W'($urandom), idx);
				end else if (pick < 94) begin
					send_request(REQ_READ, ADDR_W'($urandom), ADDR_W'($urandom),
						IDX_W'($urandom));
				end else begin
					s = $urandom_range(1, 65535);
					e = $urandom_range(0, s - 1);
					send_request(REQ_INSERT, ADDR_W'(s), ADDR_W'(e), IDX_W'($urandom));
				end
			end
			send_request(REQ_INSERT, ADDR_W'(base), ADDR_W'(base + span - 1), IDX_W'($urandom));
			sent += n + 1;
			base += span + $urandom_range(2, 40);
		end
	endtask

	initial begin
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed_cases();
		test_table_full();
		test_random_windows(2000);
		drain_results();
		repeat (40) @(posedge clk);
		$display("Checked %0d responses: %0d inserts (%0d merged, %0d dropped on full),",
			n_checked, n_inserts, n_merges, n_full);
		$display("%0d reads, %0d rejected as bad range or index; final entry count %0d",
			n_reads, n_bad, shadow_count);
		if (fail_count == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

	initial begin
		#100_000_000;
		$display("CHECKS FAILED");
		$finish;
	end

endmodule
